>>> design/smrh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smrh_pkg
// Shared types, constants and mixing functions of the salted multiply-rotate
// hash.
// ----------------------------------------------------------------------------
package smrh_pkg;

    localparam logic [1:0] OP_WORD   = 2'd0;
    localparam logic [1:0] OP_TAIL   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [63:0] SEED_BASE  = 64'h736f6d6570736575;
    localparam logic [63:0] MIX_B_INIT = 64'h646f72616e646f6d;
    localparam logic [31:0] SEED_MULT  = 32'h007C94A7;
    localparam logic [31:0] SEED_BIAS  = 32'h000000C1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;   // first mixing round from the input word
        logic tail;     // the word is a tail byte
        logic finish;   // second mixing round
        logic emit;     // load the folded hash and reseed
    } t_dp_cmd;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] scramble(input logic [63:0] t);
        scramble = (t * 64'd11) ^ rotl64(t, 17);
    endfunction

    function automatic logic [63:0] seed_of(input logic [31:0] salt);
        logic [31:0] prod;
        prod    = 32'(SEED_MULT * (salt + SEED_BIAS));
        seed_of = SEED_BASE + {32'd0, prod};
    endfunction

endpackage
`default_nettype wire

>>> design/smrh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smrh_in_if
// Input channel of the hash: one message element per word.
// ----------------------------------------------------------------------------
interface smrh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] data_word;
    logic        is_last;

    modport source(output valid, output operation, output data_word, output is_last,
                   input ready);
    modport sink(input valid, input operation, input data_word, input is_last,
                 output ready);
endinterface
`default_nettype wire

>>> design/smrh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smrh_out_if
// Output channel of the hash: one folded hash per word.
// ----------------------------------------------------------------------------
interface smrh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source(output valid, output hash_value, input ready);
    modport sink(input valid, input hash_value, output ready);
endinterface
`default_nettype wire

>>> design/smrh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smrh_dpath
// Hash state, two-round mixing datapath, salt/seed registers and the output
// hash register with its XOR fold.
// ----------------------------------------------------------------------------
module smrh_dpath #(
    parameter int HASH_OUT_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smrh_pkg::t_dp_cmd i_cmd,
    input  wire logic [63:0]       i_data_word,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [31:0]       i_cfg_wr_data,
    output logic [31:0]            o_hash_value
);
    import smrh_pkg::*;

    localparam int          NCHUNK    = (64 + HASH_OUT_BITS - 1) / HASH_OUT_BITS;
    localparam logic [63:0] CHUNK_MSK = (64'd1 << HASH_OUT_BITS) - 64'd1;

    logic [63:0] r_mix_a, n_mix_a;
    logic [63:0] r_mix_b, n_mix_b;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_salt, n_salt;
    logic [63:0] r_seed, n_seed;
    logic [31:0] r_hash, n_hash;

    logic [63:0] elem;
    logic [63:0] t1, t2, t3;
    logic [63:0] a1, a2, b1, b2;
    logic [31:0] fold;
    logic [63:0] cfg_seed;

    always_comb begin
        elem = i_cmd.tail ? {56'd0, i_data_word[7:0]} : i_data_word;
        t1   = scramble(elem) + {32'd0, r_offset} + {32'd0, r_salt};
        t2   = scramble(t1);
        t3   = scramble(t2);
        a1   = ((r_mix_a ^ elem) * 64'd13) + rotl64(t3, 23);
        // Second round works on the intermediate mix_a left by the first.
        a2   = (r_mix_a * 64'd13) + rotl64(r_mix_a, 23);
        b1   = (r_mix_b * 64'd19) + rotl64(a2, 29);
        b2   = (b1 * 64'd19) + rotl64(b1, 29);
    end

    always_comb begin
        fold = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            fold = fold ^ 32'((r_mix_b >> (c * HASH_OUT_BITS)) & CHUNK_MSK);
        end
    end

    assign cfg_seed = seed_of(i_cfg_wr_data);

    always_comb begin
        n_mix_a  = r_mix_a;
        n_mix_b  = r_mix_b;
        n_offset = r_offset;
        n_salt   = r_salt;
        n_seed   = r_seed;
        n_hash   = r_hash;
        if (i_cfg_wr_en) begin
            n_salt   = i_cfg_wr_data;
            n_seed   = cfg_seed;
            n_mix_a  = cfg_seed;
            n_mix_b  = MIX_B_INIT;
            n_offset = '0;
        end else if (i_cmd.absorb) begin
            n_mix_a  = a1;
            n_offset = r_offset + (i_cmd.tail ? 32'd1 : 32'd8);
        end else if (i_cmd.finish) begin
            n_mix_a = a2;
            n_mix_b = b2;
        end else if (i_cmd.emit) begin
            n_hash   = fold;
            n_mix_a  = r_seed;
            n_mix_b  = MIX_B_INIT;
            n_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt   <= '0;
            r_seed   <= seed_of(32'd0);
            r_mix_a  <= seed_of(32'd0);
            r_mix_b  <= MIX_B_INIT;
            r_offset <= '0;
        end else begin
            r_salt   <= n_salt;
            r_seed   <= n_seed;
            r_mix_a  <= n_mix_a;
            r_mix_b  <= n_mix_b;
            r_offset <= n_offset;
        end
        r_hash <= n_hash;
    end

    assign o_hash_value = r_hash;

endmodule
`default_nettype wire

>>> design/smrh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smrh_ctrl
// Sequencer of the hash: input handshake, mixing rounds, hash emission and
// the valid flag of the output register.
// ----------------------------------------------------------------------------
module smrh_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_operation,
    input  wire logic       i_is_last,
    output logic            o_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output smrh_pkg::t_dp_cmd o_cmd
);
    import smrh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;
    logic   is_data;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign is_data   = (i_operation == OP_WORD) || (i_operation == OP_TAIL);

    always_comb begin
        o_cmd.absorb = accept && is_data;
        o_cmd.tail   = (i_operation == OP_TAIL);
        o_cmd.finish = (r_state == S_MIX);
        o_cmd.emit   = (r_state == S_EMIT) && slot_free;
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_data) begin
                        n_state = S_MIX;
                        n_last  = i_is_last;
                    end else if (i_operation == OP_FINISH) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MIX: begin
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // A new hash never overwrites one that is still waiting.
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("hash emitted over a pending word");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted hash not presented");

    // A data element always gets its second round in the next cycle.
    a_absorb_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.absorb |=> o_cmd.finish)
        else $error("second mixing round missing");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.absorb, o_cmd.finish, o_cmd.emit}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

>>> design/salted_multiply_rotate_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salted_multiply_rotate_hash
// Salted multiply-rotate hash over 64-bit words and tail bytes.
// ----------------------------------------------------------------------------
// For each word or tail byte, the acceptance cycle runs the element
// scrambling and the first mix_a update, and the next cycle runs the second
// mix_a update and both mix_b updates. An element marked last, or a finish
// word, leads to an emit state in which the folded hash is loaded into the
// output register and the state is reseeded; that state waits while the
// output register still holds a hash that has not been taken. An unused
// operation code is accepted and does nothing. Writing the salt reseeds the
// state in the same cycle.
module salted_multiply_rotate_hash #(
    parameter int HASH_OUT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    smrh_in_if.sink          i_in,
    smrh_out_if.source       o_out
);
    import smrh_pkg::*;

    t_dp_cmd cmd;

    smrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_operation (i_in.operation),
        .i_is_last   (i_in.is_last),
        .o_ready     (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    smrh_dpath #(
        .HASH_OUT_BITS (HASH_OUT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_in.data_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_hash_value  (o_out.hash_value)
    );

endmodule
`default_nettype wire
